### hdl/half_circle_point_generator_assert.svh
// Assertion macros for the half-circle point generator.
`ifndef HALF_CIRCLE_POINT_GENERATOR_ASSERT_SVH
`define HALF_CIRCLE_POINT_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HCPG_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");
`define HCPG_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition: %m");
`else
`define HCPG_ASSERT(name, prop)
`define HCPG_NEVER(name, cond)
`endif
`endif

### hdl/hcpg_pkg.sv
`timescale 1ns / 1ps
package hcpg_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int CORDIC_ITERS = 28;
  localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [31:0] CORDIC_K_Q28 = 32'sd163008219;
  localparam logic [30:0] STEP_RESET = 31'd13107;
  localparam int DT_W = 59;

  localparam logic signed [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
    32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
    32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2
  };

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic last;
    logic truncated;
  } out_item_t;

  typedef struct packed {
    logic [30:0] step_length;
  } cfg_item_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0] radius;
    logic signed [31:0] sa;
    logic signed [31:0] ea;
    logic [DT_W-1:0] dtheta;
    logic zero;
  } arc_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0] radius;
    logic last;
    logic trunc;
  } pt_tag_t;
endpackage

### hdl/hcpg_stream_if.sv
`timescale 1ns / 1ps
interface hcpg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hdl/hcpg_setup.sv
`timescale 1ns / 1ps
module hcpg_setup import hcpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_item_t in_item,
  input  logic [30:0] step_length,
  output logic arc_valid,
  input  logic arc_ready,
  output arc_t arc
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_R2   = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_ANG  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic [5:0] cnt;
  logic signed [31:0] cx, cy;
  logic signed [32:0] dx, dy;
  logic [31:0] mx, my;
  logic [63:0] accx, accy;
  logic [63:0] v, r;
  logic [30:0] stl;
  logic [31:0] radius;
  logic zero;
  logic signed [59:0] vx0, vy0, vx1, vy1;
  logic signed [31:0] vz0, vz1;
  logic [31:0] rem;
  logic [DT_W-1:0] quo, nsh;

  logic signed [32:0] sum_x, sum_y, dx_in, dy_in;
  logic [63:0] bitv, trial, r_next, v_next;
  logic [32:0] rs;
  logic signed [59:0] sx0, sy0, sx1, sy1;
  logic signed [31:0] tab;

  assign sum_x = 33'(in_item.start_x) + 33'(in_item.end_x);
  assign sum_y = 33'(in_item.start_y) + 33'(in_item.end_y);
  assign dx_in = 33'(in_item.start_x) - 33'(in_item.end_x);
  assign dy_in = 33'(in_item.start_y) - 33'(in_item.end_y);

  assign bitv = 64'd1 << (7'd62 - 7'({cnt[4:0], 1'b0}));
  assign trial = r + bitv;
  always_comb begin
    if (v >= trial) begin
      v_next = v - trial;
      r_next = (r >> 1) + bitv;
    end else begin
      v_next = v;
      r_next = r >> 1;
    end
  end

  assign rs = {rem, nsh[DT_W-1]};
  assign tab = ATAN_TAB[cnt[4:0]];
  assign sx0 = vx0 >>> cnt[4:0];
  assign sy0 = vy0 >>> cnt[4:0];
  assign sx1 = vx1 >>> cnt[4:0];
  assign sy1 = vy1 >>> cnt[4:0];

  assign in_ready = (state == ST_IDLE);
  assign arc_valid = (state == ST_DONE);

  always_comb begin
    arc.cx = cx;
    arc.cy = cy;
    arc.radius = radius;
    arc.dtheta = quo;
    arc.zero = zero;
    if (vz0 < vz1) begin
      arc.sa = vz1;
      arc.ea = vz0;
    end else begin
      arc.sa = vz0;
      arc.ea = vz1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SQ;
            cnt <= '0;
          end
        end
        ST_SQ: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= ST_R2;
          end
        end
        ST_R2: begin
          state <= ST_ROOT;
          cnt <= '0;
        end
        ST_ROOT: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            cnt <= '0;
            state <= (r_next == 64'd0) ? ST_DONE : ST_ANG;
          end
        end
        ST_ANG: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DT_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (arc_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cx <= sum_x[32:1];
          cy <= sum_y[32:1];
          dx <= dx_in;
          dy <= dy_in;
          mx <= dx_in[32] ? 32'(-dx_in) : dx_in[31:0];
          my <= dy_in[32] ? 32'(-dy_in) : dy_in[31:0];
          accx <= '0;
          accy <= '0;
          stl <= step_length;
        end
      end
      ST_SQ: begin
        if (mx[cnt[4:0]]) begin
          accx <= accx + ({32'd0, mx} << cnt[4:0]);
        end
        if (my[cnt[4:0]]) begin
          accy <= accy + ({32'd0, my} << cnt[4:0]);
        end
      end
      ST_R2: begin
        v <= (accx >> 2) + (accy >> 2);
        r <= '0;
        vx0 <= dx[32] ? -(60'(dx) <<< 24) : (60'(dx) <<< 24);
        vy0 <= dx[32] ? -(60'(dy) <<< 24) : (60'(dy) <<< 24);
        vz0 <= dx[32] ? (dy[32] ? -PI_Q28 : PI_Q28) : 32'sd0;
        vx1 <= (dx > 0) ? (60'(dx) <<< 24) : -(60'(dx) <<< 24);
        vy1 <= (dx > 0) ? (60'(dy) <<< 24) : -(60'(dy) <<< 24);
        vz1 <= (dx > 0) ? ((dy <= 0) ? PI_Q28 : -PI_Q28) : 32'sd0;
        rem <= '0;
        quo <= '0;
        nsh <= {stl, 28'd0};
      end
      ST_ROOT: begin
        v <= v_next;
        r <= r_next;
        if (cnt == 6'd31) begin
          radius <= r_next[31:0];
          zero <= (r_next == 64'd0);
        end
      end
      ST_ANG: begin
        if (rs >= {1'b0, radius}) begin
          rem <= 32'(rs - {1'b0, radius});
          quo <= {quo[DT_W-2:0], 1'b1};
        end else begin
          rem <= rs[31:0];
          quo <= {quo[DT_W-2:0], 1'b0};
        end
        nsh <= nsh << 1;
        if (cnt < 6'(CORDIC_ITERS)) begin
          if (vy0 < 0) begin
            vx0 <= vx0 - sy0;
            vy0 <= vy0 + sx0;
            vz0 <= vz0 - tab;
          end else begin
            vx0 <= vx0 + sy0;
            vy0 <= vy0 - sx0;
            vz0 <= vz0 + tab;
          end
          if (vy1 < 0) begin
            vx1 <= vx1 - sy1;
            vy1 <= vy1 + sx1;
            vz1 <= vz1 - tab;
          end else begin
            vx1 <= vx1 + sy1;
            vy1 <= vy1 - sx1;
            vz1 <= vz1 + tab;
          end
        end
      end
      default: begin
      end
    endcase
  end
endmodule

### hdl/hcpg_sincos.sv
`timescale 1ns / 1ps
module hcpg_sincos import hcpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic signed [31:0] theta,
  input  pt_tag_t in_tag,
  output logic out_valid,
  output out_item_t out_item
);
  localparam int N = CORDIC_ITERS;

  logic vld [N+1];
  logic neg [N+1];
  logic signed [31:0] x [N+1];
  logic signed [31:0] y [N+1];
  logic signed [31:0] z [N+1];
  pt_tag_t tag [N+1];

  logic signed [31:0] zf;
  logic nf;
  always_comb begin
    zf = theta;
    nf = 1'b0;
    if (theta > HALF_PI_Q28) begin
      zf = theta - PI_Q28;
      nf = 1'b1;
    end else if (theta < -HALF_PI_Q28) begin
      zf = theta + PI_Q28;
      nf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
    if (adv) begin
      x[0] <= CORDIC_K_Q28;
      y[0] <= '0;
      z[0] <= zf;
      neg[0] <= nf;
      tag[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [31:0] xs, ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        if (!z[i][31]) begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + ATAN_TAB[i];
        end
        neg[i+1] <= neg[i];
        tag[i+1] <= tag[i];
      end
    end
  end

  logic signed [31:0] cval, sval;
  logic signed [64:0] px, py;
  logic mvld;
  pt_tag_t mtag;
  assign cval = neg[N] ? -x[N] : x[N];
  assign sval = neg[N] ? -y[N] : y[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= 1'b0;
    end else if (adv) begin
      mvld <= vld[N];
    end
    if (adv) begin
      px <= $signed({1'b0, tag[N].radius}) * cval;
      py <= $signed({1'b0, tag[N].radius}) * sval;
      mtag <= tag[N];
    end
  end

  logic signed [64:0] rx, ry;
  logic signed [37:0] sx, sy;
  logic signed [31:0] qx, qy;
  assign rx = (px + 65'sd134217728) >>> 28;
  assign ry = (py + 65'sd134217728) >>> 28;
  assign sx = 38'(mtag.cx) + rx[37:0];
  assign sy = 38'(mtag.cy) + ry[37:0];
  always_comb begin
    if (sx > 38'sd2147483647) begin
      qx = 32'sh7fffffff;
    end else if (sx < -38'sd2147483648) begin
      qx = 32'sh80000000;
    end else begin
      qx = sx[31:0];
    end
    if (sy > 38'sd2147483647) begin
      qy = 32'sh7fffffff;
    end else if (sy < -38'sd2147483648) begin
      qy = 32'sh80000000;
    end else begin
      qy = sy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mvld;
    end
    if (adv) begin
      out_item.point_x <= qx;
      out_item.point_y <= qy;
      out_item.last <= mtag.last;
      out_item.truncated <= mtag.trunc;
    end
  end
endmodule

### hdl/half_circle_point_generator.sv
`timescale 1ns / 1ps
// Flow: an accepted item passes the setup unit before its first point issues, then goes
// through the sine/cosine pipeline to the output register.
// Throughput: one point per cycle while the output is taken; the setup unit takes no new item
// until the last one has passed its serial squaring, square root and 59-step divider.
// Reset is synchronous and active high; it empties all stages and sets step_length to 13107.
`include "half_circle_point_generator_assert.svh"
module half_circle_point_generator import hcpg_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input logic clk,
  input logic rst,
  hcpg_stream_if.sink arc_in,
  hcpg_stream_if.source point_out,
  hcpg_stream_if.sink cfg
);
  localparam int CNT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int TH_W = 62;

  logic [30:0] step_length;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_RESET;
    end else if (cfg.valid) begin
      step_length <= cfg.data.step_length;
    end
  end

  logic arc_valid, arc_ready;
  arc_t arc;
  hcpg_setup u_setup (
    .clk(clk),
    .rst(rst),
    .in_valid(arc_in.valid),
    .in_ready(arc_in.ready),
    .in_item(arc_in.data),
    .step_length(step_length),
    .arc_valid(arc_valid),
    .arc_ready(arc_ready),
    .arc(arc)
  );

  logic active;
  logic adv;
  logic signed [TH_W-1:0] theta, ea, next_theta;
  logic [DT_W-1:0] dtheta;
  logic [CNT_W-1:0] n;
  logic zero;
  logic signed [31:0] cx, cy;
  logic [31:0] radius;
  logic at_max, below, iss_last;
  pt_tag_t iss_tag;

  assign adv = !point_out.valid || point_out.ready;
  assign arc_ready = !active;
  assign next_theta = theta - TH_W'(dtheta);
  assign below = next_theta < ea;
  assign at_max = (n == CNT_W'(MAX_POINTS - 1));
  assign iss_last = zero || below || at_max;

  always_comb begin
    iss_tag.cx = cx;
    iss_tag.cy = cy;
    iss_tag.radius = radius;
    iss_tag.last = iss_last;
    iss_tag.trunc = !zero && at_max && !below;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (!active) begin
      active <= arc_valid;
    end else if (adv && iss_last) begin
      active <= 1'b0;
    end
    if (!active) begin
      theta <= TH_W'(arc.sa);
      ea <= TH_W'(arc.ea);
      dtheta <= arc.dtheta;
      zero <= arc.zero;
      cx <= arc.cx;
      cy <= arc.cy;
      radius <= arc.radius;
      n <= '0;
    end else if (adv) begin
      theta <= next_theta;
      n <= n + CNT_W'(1);
    end
  end

  hcpg_sincos u_sincos (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(active),
    .theta(theta[31:0]),
    .in_tag(iss_tag),
    .out_valid(point_out.valid),
    .out_item(point_out.data)
  );

  `HCPG_ASSERT(a_trunc_is_last, point_out.valid && point_out.data.truncated |-> point_out.data.last)
  `HCPG_ASSERT(a_stall_holds_theta, active && !adv |=> $stable(theta) && $stable(n))
  `HCPG_ASSERT(a_last_ends_arc, active && adv && iss_last |=> !active)
  `HCPG_NEVER(a_zero_multi, active && zero && n != '0)
endmodule

### sim/half_circle_point_generator_tb.sv
`timescale 1ns / 1ps
module half_circle_point_generator_tb;
  import hcpg_pkg::*;

  logic clk;
  logic rst;

  hcpg_stream_if #(.T(in_item_t)) arc_in ();
  hcpg_stream_if #(.T(out_item_t)) point_out ();
  hcpg_stream_if #(.T(cfg_item_t)) cfg ();

  half_circle_point_generator DUT (
    .clk(clk),
    .rst(rst),
    .arc_in(arc_in),
    .point_out(point_out),
    .cfg(cfg)
  );

  out_item_t expected_points[$];
  logic [30:0] step_len;
  int errors;
  int arcs_sent;
  int points_seen;
  int truncated_seen;
  int burst_left;
  int idle_cycles;
  int ready_mode;
  int mode_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint arc_angle(longint y, longint x);
    longint base;
    longint z;
    longint xs;
    longint ys;
    base = 0;
    z = 0;
    x = x * 64'sd16777216;
    y = y * 64'sd16777216;
    if (x < 0) begin
      base = (y >= 0) ? longint'(PI_Q28) : -longint'(PI_Q28);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    return base + z;
  endfunction

  task automatic sin_cos(input longint theta, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    bit flip;
    x = longint'(CORDIC_K_Q28);
    y = 0;
    z = theta;
    flip = 1'b0;
    if (z > longint'(HALF_PI_Q28)) begin
      z = z - longint'(PI_Q28);
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q28)) begin
      z = z + longint'(PI_Q28);
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_arc(input in_item_t a);
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint unsigned mx;
    longint unsigned my;
    longint unsigned r2;
    longint unsigned radius;
    longint sa;
    longint ea;
    longint t;
    longint dtheta;
    longint theta;
    longint c;
    longint s;
    out_item_t p;
    out_item_t pts[$];
    ax = a.start_x;
    ay = a.start_y;
    bx = a.end_x;
    by = a.end_y;
    cx = (ax + bx) >>> 1;
    cy = (ay + by) >>> 1;
    dx = ax - bx;
    dy = ay - by;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    r2 = ((mx * mx) >> 2) + ((my * my) >> 2);
    radius = int_sqrt(r2);
    if (radius == 0) begin
      p.point_x = clamp32(cx);
      p.point_y = clamp32(cy);
      p.last = 1'b1;
      p.truncated = 1'b0;
      expected_points.push_back(p);
      return;
    end
    sa = arc_angle(dy, dx);
    ea = arc_angle(-dy, -dx);
    if (sa < ea) begin
      t = sa;
      sa = ea;
      ea = t;
    end
    dtheta = longint'((longint'(step_len) << 28) / radius);
    theta = sa;
    while (theta >= ea && pts.size() < MAX_POINTS_DEF) begin
      sin_cos(theta, c, s);
      p.point_x = clamp32(cx + ((longint'(radius) * c + 64'sd134217728) >>> 28));
      p.point_y = clamp32(cy + ((longint'(radius) * s + 64'sd134217728) >>> 28));
      p.last = 1'b0;
      p.truncated = 1'b0;
      pts.push_back(p);
      theta = theta - dtheta;
    end
    pts[pts.size() - 1].last = 1'b1;
    if (theta >= ea) pts[pts.size() - 1].truncated = 1'b1;
    foreach (pts[i]) expected_points.push_back(pts[i]);
  endtask

  // The sender runs in bursts; between bursts valid is held low for a gap so that
  // valid is never lowered and raised at the same edge.
  task automatic send_arc(input in_item_t a);
    if (burst_left == 0) begin
      @(negedge clk);
      arc_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end else begin
      @(negedge clk);
    end
    arc_in.valid <= 1'b1;
    arc_in.data <= a;
    @(posedge clk);
    while (!arc_in.ready) @(posedge clk);
    predict_arc(a);
    arcs_sent++;
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    arc_in.valid <= 1'b0;
    burst_left = 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_step(input logic [30:0] val);
    wait_drained();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data.step_length <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    step_len = val;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic in_item_t make_arc(logic [31:0] ax, logic [31:0] ay,
                                        logic [31:0] bx, logic [31:0] by);
    in_item_t a;
    a.start_x = ax;
    a.start_y = ay;
    a.end_x = bx;
    a.end_y = by;
    return a;
  endfunction

  function automatic in_item_t random_arc();
    logic [31:0] ax;
    logic [31:0] ay;
    int k;
    ax = $urandom;
    ay = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return make_arc(ax, ay, $urandom, $urandom);
      2: return make_arc(ax, ay, ax + $urandom_range(0, 2) - 1, ay + $urandom_range(0, 2) - 1);
      default: begin
        k = $urandom_range(1, 24);
        return make_arc(ax, ay, ax + ($urandom & ((32'd1 << k) - 1)) - (32'd1 << (k - 1)),
                        ay + ($urandom & ((32'd1 << k) - 1)) - (32'd1 << (k - 1)));
      end
    endcase
  endfunction

  task automatic test_directed_arcs();
    send_arc(make_arc(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000));
    send_arc(make_arc(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001));
    send_arc(make_arc(32'h0000_0000, 32'h0000_0000, 32'h0000_0002, 32'h0000_0000));
    send_arc(make_arc(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000));
    send_arc(make_arc(32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000));
    send_arc(make_arc(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000));
    send_arc(make_arc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_arc(make_arc(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_arc(make_arc(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000));
    send_arc(make_arc(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_arc(make_arc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_arc(make_arc(32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
  endtask

  task automatic test_step_extremes();
    write_step(31'd1);
    send_arc(make_arc(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000));
    send_arc(make_arc(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_arc(make_arc(32'h0000_0000, 32'h0000_0000, 32'h0000_0004, 32'h0000_0000));
    write_step(31'h7FFF_FFFF);
    send_arc(make_arc(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000));
    send_arc(make_arc(32'h0000_0000, 32'h0000_0000, 32'h0000_0004, 32'h0000_0004));
    send_arc(make_arc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    write_step(STEP_RESET);
    send_arc(make_arc(32'h0002_0000, 32'h0001_0000, 32'hFFFE_0000, 32'hFFFF_0000));
  endtask

  task automatic test_random_arcs();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_step(31'd1 << $urandom_range(10, 20));
        1: write_step(31'($urandom_range(1, 64)));
        2: write_step(31'($urandom));
        3: write_step(31'h7FFF_FFFF - 31'($urandom_range(0, 15)));
        default: write_step(31'($urandom_range(1000, 200000)));
      endcase
      for (int i = 0; i < 44; i++) begin
        send_arc(random_arc());
        if (ph == 4 && i == 20) wait_drained();
      end
    end
  endtask

  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_cycles = $urandom_range(50, 300);
    end
    mode_cycles--;
    case (ready_mode)
      0: point_out.ready <= 1'b1;
      1: point_out.ready <= ($urandom_range(0, 1) == 1);
      default: point_out.ready <= (mode_cycles % 7 < 4);
    endcase
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && point_out.valid && point_out.ready) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        $error("point beat with nothing expected: x=%h y=%h",
               point_out.data.point_x, point_out.data.point_y);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (e.truncated) truncated_seen++;
        if (point_out.data.point_x !== e.point_x) begin
          $error("point_x expected %h actual %h", e.point_x, point_out.data.point_x);
          errors++;
        end
        if (point_out.data.point_y !== e.point_y) begin
          $error("point_y expected %h actual %h", e.point_y, point_out.data.point_y);
          errors++;
        end
        if (point_out.data.last !== e.last) begin
          $error("last expected %b actual %b", e.last, point_out.data.last);
          errors++;
        end
        if (point_out.data.truncated !== e.truncated) begin
          $error("truncated expected %b actual %b", e.truncated, point_out.data.truncated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (arc_in.valid && arc_in.ready) || (point_out.valid && point_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    arcs_sent = 0;
    points_seen = 0;
    truncated_seen = 0;
    burst_left = 0;
    idle_cycles = 0;
    mode_cycles = 0;
    ready_mode = 0;
    step_len = STEP_RESET;
    rst = 1'b1;
    arc_in.valid = 1'b0;
    arc_in.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    point_out.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_arcs();
    test_step_extremes();
    test_random_arcs();
    wait_drained();
    $display("Sent %0d arcs over several step lengths including both extremes,", arcs_sent);
    $display("checked %0d points, %0d of them cut at the point limit.",
             points_seen, truncated_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
